// ----- src/shash_pkg.sv -----
// ----------------------------------------------------------------------------
// SeaHash four-lane hasher package
// Shared constants, the queue item type and the sequencer state type.
// ----------------------------------------------------------------------------
package shash_pkg;

    localparam int WORD_W      = 64;
    localparam int COUNT_W     = 4;
    localparam int NUM_LANES   = 4;
    localparam int LANE_IDX_W  = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [COUNT_W-1:0] BYTES_PER_WORD = 4'd8;

    localparam logic [WORD_W-1:0] DIFFUSE_MUL = 64'h6eed0e9da4d94a4f;
    localparam logic [WORD_W-1:0] SEED0_RESET = 64'h16f11fe89b0d677c;
    localparam logic [WORD_W-1:0] SEED1_RESET = 64'hb480a793d8e6c86c;
    localparam logic [WORD_W-1:0] SEED2_RESET = 64'h6fe2e5aaf078ebc9;
    localparam logic [WORD_W-1:0] SEED3_RESET = 64'h14f994a4c5259381;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LANE0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LANE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LANE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LANE3 = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
        logic               last;
    } shash_item_t;

    typedef struct packed {
        logic        valid;
        shash_item_t item;
    } shash_queue_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1_LO,
        ST_MUL1_HI,
        ST_SHIFT,
        ST_MUL2_LO,
        ST_MUL2_HI,
        ST_FOLD
    } shash_state_t;

endpackage

// ----- src/seahash_four_lane_hasher_unit.sv -----
// ----------------------------------------------------------------------------
// SeaHash four-lane hasher
// Computes the 64-bit SeaHash of a message streamed as little-endian words.
// ----------------------------------------------------------------------------
// Input channel (s_*): one transaction per message word, up to eight bytes,
// with s_byte_count giving the valid bytes and s_last_word closing the
// message. An empty message is a single transaction with zero bytes and the
// last mark. Output channel (m_*): one transaction per message, carrying
// the hash. The user is to write seeds on the cfg_* port only while the
// block is idle; the block itself does not enforce this. Seeds take effect
// at the next message. Words pass through a small queue into a sequencer
// that owns one shared multiplier. Each word with data is handled there in
// steps: the lane load, a 64-bit multiply in a low and a high step, the
// shift step and a second multiply. Closing a message runs the fold and then
// its diffusion through the same multiply, shift and multiply steps. The
// front keeps accepting words while the queue has room.
// Reset restores the default seeds and empties the queue and the output
// register. When the receiver stalls, the hash waits in the output register
// and the queue absorbs further words until it fills.
// ----------------------------------------------------------------------------
module seahash_four_lane_hasher_unit #(
    parameter int QueueDepth = shash_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [shash_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [shash_pkg::WORD_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [shash_pkg::WORD_W-1:0]      s_data_word,
    input  logic [shash_pkg::COUNT_W-1:0]     s_byte_count,
    input  logic                              s_last_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [shash_pkg::WORD_W-1:0]      m_hash_value
);
    import shash_pkg::*;

    shash_queue_head_t q_head;
    logic              q_pop;

    shash_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last_word  (s_last_word),
        .q_head       (q_head),
        .q_pop        (q_pop)
    );

    shash_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule

// ----- src/shash_front.sv -----
// ----------------------------------------------------------------------------
// SeaHash front end
// Accepts words, clamps the byte count, masks unused bytes and queues them.
// ----------------------------------------------------------------------------
module shash_front #(
    parameter int QueueDepth = shash_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [shash_pkg::WORD_W-1:0]       s_data_word,
    input  logic [shash_pkg::COUNT_W-1:0]      s_byte_count,
    input  logic                               s_last_word,
    output shash_pkg::shash_queue_head_t       q_head,
    input  logic                               q_pop
);
    import shash_pkg::*;

    localparam int PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CNT_W = $clog2(QueueDepth + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QueueDepth - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QueueDepth);

    shash_item_t        queue_reg [QueueDepth];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               push, pop;
    logic [COUNT_W-1:0] count_clamped;
    logic [WORD_W-1:0]  word_masked;
    shash_item_t        new_item;

    always_comb begin
        count_clamped = (s_byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : s_byte_count;
        for (int b = 0; b < 8; b++) begin
            word_masked[b*8 +: 8] = (COUNT_W'(b) < count_clamped) ? s_data_word[b*8 +: 8]
                                                                  : 8'h00;
        end
        new_item.word  = word_masked;
        new_item.count = count_clamped;
        new_item.last  = s_last_word;
    end

    assign s_ready      = (fill_reg != FULL_CNT);
    assign push         = s_valid && s_ready;
    assign q_head.valid = (fill_reg != '0);
    assign q_head.item  = queue_reg[rd_ptr_reg];
    assign pop          = q_pop && q_head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- src/shash_mul.sv -----
// ----------------------------------------------------------------------------
// SeaHash diffusion multiplier
// 64-bit by constant multiply in a low and a high step, keeping the low 64 product bits.
// ----------------------------------------------------------------------------
module shash_mul (
    input  logic                         aclk,
    input  logic                         lo_en,
    input  logic [shash_pkg::WORD_W-1:0] operand,
    output logic [shash_pkg::WORD_W-1:0] product
);
    import shash_pkg::*;

    logic [WORD_W-1:0] low_prod_reg;
    logic [WORD_W-1:0] low_prod_next;
    logic [31:0]       cross_a, cross_b;

    assign low_prod_next = {32'b0, operand[31:0]} * {32'b0, DIFFUSE_MUL[31:0]};
    assign cross_a       = operand[31:0] * DIFFUSE_MUL[63:32];
    assign cross_b       = operand[63:32] * DIFFUSE_MUL[31:0];
    assign product       = low_prod_reg + {cross_a + cross_b, 32'b0};

    always_ff @(posedge aclk) begin
        if (lo_en) begin
            low_prod_reg <= low_prod_next;
        end
    end

endmodule

// ----- src/shash_core.sv -----
// ----------------------------------------------------------------------------
// SeaHash back end
// Holds the seeds and lanes, runs the diffusion sequence and the final fold.
// ----------------------------------------------------------------------------
module shash_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [shash_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shash_pkg::WORD_W-1:0]        cfg_data,
    input  shash_pkg::shash_queue_head_t        q_head,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [shash_pkg::WORD_W-1:0]        m_hash_value
);
    import shash_pkg::*;

    shash_state_t          state_reg, state_next;
    logic [WORD_W-1:0]     seed_reg [NUM_LANES];
    logic [WORD_W-1:0]     lane_reg [NUM_LANES];
    logic [LANE_IDX_W-1:0] ptr_reg;
    logic [WORD_W-1:0]     total_reg;
    logic                  in_msg_reg;
    logic                  last_reg;
    logic                  final_reg;
    logic [WORD_W-1:0]     acc_reg;
    logic                  out_valid_reg;
    logic [WORD_W-1:0]     out_hash_reg;

    logic                  mul_lo_en;
    logic                  fold_go;
    logic                  msg_start;
    logic [WORD_W-1:0]     lane_cur;
    logic [WORD_W-1:0]     total_base;
    logic [WORD_W-1:0]     product;
    logic [WORD_W-1:0]     shifted;

    shash_mul u_mul (
        .aclk    (aclk),
        .lo_en   (mul_lo_en),
        .operand (acc_reg),
        .product (product)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_head.valid) begin
                    if (q_head.item.count != '0) begin
                        state_next = ST_MUL1_LO;
                    end else if (q_head.item.last) begin
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_MUL1_LO: state_next = ST_MUL1_HI;
            ST_MUL1_HI: state_next = ST_SHIFT;
            ST_SHIFT:   state_next = ST_MUL2_LO;
            ST_MUL2_LO: state_next = ST_MUL2_HI;
            ST_MUL2_HI: begin
                if (!final_reg && last_reg) begin
                    state_next = ST_FOLD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FOLD: begin
                if (fold_go) begin
                    state_next = ST_MUL1_LO;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        mul_lo_en = 1'b0;
        fold_go   = 1'b0;
        unique case (state_reg)
            ST_IDLE:    q_pop     = q_head.valid;
            ST_MUL1_LO: mul_lo_en = 1'b1;
            ST_MUL2_LO: mul_lo_en = 1'b1;
            ST_FOLD:    fold_go   = !out_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    assign msg_start  = !in_msg_reg;
    assign lane_cur   = msg_start ? seed_reg[0] : lane_reg[ptr_reg];
    assign total_base = msg_start ? '0 : total_reg;
    assign shifted    = acc_reg ^ ((acc_reg >> 32) >> acc_reg[63:60]);

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            in_msg_reg    <= 1'b0;
            last_reg      <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg[0]   <= SEED0_RESET;
            seed_reg[1]   <= SEED1_RESET;
            seed_reg[2]   <= SEED2_RESET;
            seed_reg[3]   <= SEED3_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SEED_LANE0: seed_reg[0] <= cfg_data;
                    CFG_SEED_LANE1: seed_reg[1] <= cfg_data;
                    CFG_SEED_LANE2: seed_reg[2] <= cfg_data;
                    CFG_SEED_LANE3: seed_reg[3] <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                last_reg   <= q_head.item.last;
                final_reg  <= 1'b0;
                in_msg_reg <= 1'b1;
                if (msg_start) begin
                    ptr_reg <= '0;
                end
                if (q_head.item.count == '0 && q_head.item.last) begin
                    in_msg_reg <= 1'b1;
                end
            end
            if (fold_go) begin
                final_reg <= 1'b1;
            end
            if (state_reg == ST_MUL2_HI) begin
                if (final_reg) begin
                    out_valid_reg <= 1'b1;
                    in_msg_reg    <= 1'b0;
                end else begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            acc_reg   <= lane_cur ^ q_head.item.word;
            total_reg <= total_base + {{(WORD_W-COUNT_W){1'b0}}, q_head.item.count};
            if (msg_start) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    lane_reg[i] <= seed_reg[i];
                end
            end
        end
        if (state_reg == ST_MUL1_HI) begin
            acc_reg <= product;
        end
        if (state_reg == ST_SHIFT) begin
            acc_reg <= shifted;
        end
        if (fold_go) begin
            acc_reg <= (lane_reg[0] ^ lane_reg[1]) ^ (lane_reg[2] ^ lane_reg[3]) ^ total_reg;
        end
        if (state_reg == ST_MUL2_HI) begin
            if (final_reg) begin
                out_hash_reg <= product;
            end else begin
                lane_reg[ptr_reg] <= product;
            end
        end
    end

endmodule

// ----- src/shash_checker.sv -----
// ----------------------------------------------------------------------------
// SeaHash hasher port checker
// Watches the top-level ports for reset, ordering and output behavior.
// ----------------------------------------------------------------------------
module shash_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_last_word,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [shash_pkg::WORD_W-1:0] m_hash_value
);
    import shash_pkg::*;

    logic [7:0] pending_reg;
    logic       last_in;
    logic       hash_out;

    assign last_in  = s_valid && s_ready && s_last_word;
    assign hash_out = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (last_in && !hash_out) begin
            pending_reg <= pending_reg + 1'b1;
        end else if (hash_out && !last_in) begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_hash_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != '0))
        else $error("hash presented without a closed message");

    a_stall_holds_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("hash changed while stalled");

endmodule

bind seahash_four_lane_hasher_unit shash_checker u_shash_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_last_word  (s_last_word),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_value (m_hash_value)
);
